>>> sv/ple_pkg.sv
// Shared types, constants and helpers for the piecewise-linear envelope generator.
// Used by ple_table, ple_arith and piecewise_linear_envelope; depends on nothing.
package ple_pkg;

  // Table geometry and field widths.
  localparam int MaxPoints = 8;
  localparam int PtIdxW    = $clog2(MaxPoints);
  localparam int TickW     = 24;
  localparam int LevelW    = 16;
  localparam int CountW    = 4;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 24;
  localparam int StepW     = $clog2(LevelW);

  // Reset values.
  localparam logic [TickW-1:0]  ResetTime1   = 24'd1000000;
  localparam logic [TickW-1:0]  DecayReset   = 24'd100000;
  localparam logic [CountW-1:0] CountReset   = 4'd2;
  localparam logic [CountW-1:0] CountMin     = 4'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPointCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDecayTime  = 1'd1;

  // Input item kinds.
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEval = 1'b1;

  typedef struct packed {
    logic [TickW-1:0]  ptime;
    logic [LevelW-1:0] plevel;
  } tbl_entry_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PtIdxW-1:0] addr;
    tbl_entry_t        wdata;
  } tbl_req_t;

  typedef struct packed {
    logic              start;
    logic [LevelW-1:0] mag;
    logic [TickW-1:0]  dt;
    logic [TickW-1:0]  span;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [LevelW-1:0] quotient;
  } arith_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUS_CHK,
    S_SUS_LVL,
    S_SCAN,
    S_LO,
    S_DIV
  } ple_state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV
  } arith_state_e;

  // Contents of a table entry that has not been written since reset.
  function automatic tbl_entry_t reset_entry(input logic [PtIdxW-1:0] addr);
    tbl_entry_t e;
    e.ptime  = (addr == PtIdxW'(1)) ? ResetTime1 : '0;
    e.plevel = '0;
    return e;
  endfunction

endpackage

>>> sv/ple_table.sv
// Breakpoint table: one synchronous memory of (time, level) pairs with registered reads.
// Unwritten entries read as their reset values through per-entry valid bits. Uses ple_pkg.
module ple_table import ple_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tbl_req_t   req_i,
  output tbl_entry_t rdata_o
);

  tbl_entry_t              mem_q [MaxPoints];
  logic [MaxPoints-1:0]    valid_q;
  tbl_entry_t              rd_q;
  logic                    rd_valid_q;
  logic [PtIdxW-1:0]       rd_addr_q;

  // Memory array: one write or one read per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q      <= mem_q[req_i.addr];
      rd_addr_q <= req_i.addr;
    end
  end

  // Valid bits mark entries written since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  // An entry never written returns its reset contents.
  assign rdata_o = rd_valid_q ? rd_q : reset_entry(rd_addr_q);

  // The sequencer never writes and reads the table in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.we && req_i.re))
    else $error("table written and read in the same cycle");

  // A write leaves the entry marked valid.
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.we |=> valid_q[$past(req_i.addr)])
    else $error("written entry not marked valid");

  // A read of a valid entry returns the stored contents.
  a_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.re && valid_q[req_i.addr]) |=> rd_valid_q)
    else $error("read of written entry returned reset contents");

endmodule

>>> sv/ple_arith.sv
// Shared multiply and serial divide unit: quotient = (mag * dt) / span, truncated.
// The quotient must fit in LevelW bits (dt <= span). Uses ple_pkg.
module ple_arith import ple_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  arith_state_e      state_q, state_d;
  logic [LevelW-1:0] mag_q, mag_d;
  logic [TickW-1:0]  dt_q, dt_d;
  logic [TickW-1:0]  span_q, span_d;
  logic [TickW-1:0]  rem_q, rem_d;
  logic [LevelW-1:0] quo_q, quo_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [TickW+LevelW-1:0] prod;
  logic [TickW:0]    trial;
  logic [TickW:0]    diff;
  logic              ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign prod  = (TickW+LevelW)'(mag_q) * (TickW+LevelW)'(dt_q);
  assign trial = {rem_q, quo_q[LevelW-1]};
  assign diff  = trial - {1'b0, span_q};
  assign ge    = (trial >= {1'b0, span_q});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) state_d = A_MUL;
      end
      A_MUL: begin
        state_d = A_DIV;
      end
      A_DIV: begin
        if (cnt_q == StepW'(LevelW - 1)) state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    mag_d  = mag_q;
    dt_d   = dt_q;
    span_d = span_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          mag_d  = req_i.mag;
          dt_d   = req_i.dt;
          span_d = req_i.span;
        end
      end
      A_MUL: begin
        // Upper product bits are below span since the quotient fits LevelW bits.
        rem_d = prod[TickW+LevelW-1:LevelW];
        quo_d = prod[LevelW-1:0];
        cnt_d = '0;
      end
      A_DIV: begin
        rem_d = ge ? diff[TickW-1:0] : trial[TickW-1:0];
        quo_d = {quo_q[LevelW-2:0], ge};
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(LevelW - 1)) done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    dt_q   <= dt_d;
    span_q <= span_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // The partial remainder stays below the divisor throughout the divide.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == A_DIV) |-> (rem_q < span_q))
    else $error("partial remainder not below divisor");

  // Completion follows the last divide step only.
  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == A_DIV) && (state_q == A_IDLE))
    else $error("divide completion out of sequence");

  // A start request is only made while the unit is free.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == A_IDLE))
    else $error("divide started while busy");

endmodule

>>> sv/piecewise_linear_envelope.sv
// Top level of the piecewise-linear envelope generator: command port, sequencer and
// configuration registers. Depends on ple_pkg, ple_table and ple_arith.
//
// Items are taken on start while busy is low. A load item writes one breakpoint and busy
// stays low. A release evaluate at or past the decay time returns its result in the next
// cycle. A release ramp runs a multiply and a serial divide; a held evaluate reads the table
// once per segment visited on the single memory port, then runs at most a multiply and a
// 16-step serial divide. Each result appears for exactly one cycle with valid_o high and
// must be taken then; the next item may be started while it shows.
module piecewise_linear_envelope import ple_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                mode_i,
  input  logic [2:0]          point_index_i,
  input  logic [TickW-1:0]    point_time_i,
  input  logic [LevelW-1:0]   point_level_i,
  input  logic [TickW-1:0]    elapsed_time_i,
  input  logic                key_pressed_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                valid_o,
  output logic [LevelW-1:0]   level_o,
  output logic                releasing_o
);

  ple_state_e         state_q, state_d;
  logic [CountW-1:0]  count_q;
  logic [TickW-1:0]   decay_q;
  logic [PtIdxW-1:0]  seg_q, seg_d;
  logic [LevelW-1:0]  rel_q, rel_d;
  logic [TickW-1:0]   t_q, t_d;
  logic [TickW-1:0]   x1_q, x1_d;
  logic [LevelW-1:0]  y1_q, y1_d;
  logic [LevelW-1:0]  y0_q, y0_d;
  logic               up_q, up_d;
  logic               ramp_q, ramp_d;
  logic               valid_q, valid_d;
  logic [LevelW-1:0]  level_q, level_d;
  logic               releasing_q, releasing_d;

  tbl_req_t           tbl_req;
  tbl_entry_t         rd;
  arith_req_t         arith_req;
  arith_rsp_t         arith_rsp;

  logic               accept;
  logic [CountW-1:0]  n_used;
  logic [PtIdxW-1:0]  last;
  logic [PtIdxW-1:0]  seg_clamp;
  logic               sus_hit;
  logic               scan_more;
  logic               flat_seg;
  logic               decay_zero;
  logic [TickW-1:0]   t_clamp;
  logic [LevelW-1:0]  div_level;

  ple_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .rdata_o (rd)
  );

  ple_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
      decay_q <= DecayReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPointCount: count_q <= cfg_data_i[CountW-1:0];
        CfgDecayTime:  decay_q <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Decisions shared by the sequencer blocks.
  assign accept = start && !busy;

  always_comb begin
    if (count_q < CountMin) begin
      n_used = CountMin;
    end else if (32'(count_q) > MaxPoints) begin
      n_used = CountW'(MaxPoints);
    end else begin
      n_used = count_q;
    end
  end

  assign last       = PtIdxW'(n_used - CountW'(1));
  assign seg_clamp  = (seg_q > last) ? last : seg_q;
  assign sus_hit    = (t_q > rd.ptime);
  assign scan_more  = (seg_q < last) && (t_q > rd.ptime);
  assign flat_seg   = (x1_q <= rd.ptime);
  assign decay_zero = (decay_q == '0) || (elapsed_time_i >= decay_q);
  assign t_clamp    = (t_q < rd.ptime) ? rd.ptime : ((t_q > x1_q) ? x1_q : t_q);
  assign div_level  = ramp_q ? arith_rsp.quotient :
                      (up_q ? (y0_q + arith_rsp.quotient) : (y0_q - arith_rsp.quotient));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (mode_i == ModeEval)) begin
          if (key_pressed_i) begin
            state_d = S_SUS_CHK;
          end else if (!decay_zero) begin
            state_d = S_DIV;
          end
        end
      end
      S_SUS_CHK: state_d = sus_hit ? S_SUS_LVL : S_SCAN;
      S_SUS_LVL: state_d = S_IDLE;
      S_SCAN:    state_d = scan_more ? S_SCAN : S_LO;
      S_LO:      state_d = flat_seg ? S_IDLE : S_DIV;
      S_DIV:     state_d = arith_rsp.done ? S_IDLE : S_DIV;
      default:   state_d = S_IDLE;
    endcase
  end

  // Table accesses, divide requests and register updates.
  always_comb begin
    tbl_req         = '0;
    arith_req       = '0;
    seg_d           = seg_q;
    rel_d           = rel_q;
    t_d             = t_q;
    x1_d            = x1_q;
    y1_d            = y1_q;
    y0_d            = y0_q;
    up_d            = up_q;
    ramp_d          = ramp_q;
    valid_d         = 1'b0;
    level_d         = level_q;
    releasing_d     = releasing_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          t_d = elapsed_time_i;
          if (mode_i == ModeLoad) begin
            // Load: write one breakpoint and restart the segment scan.
            if (32'(point_index_i) < MaxPoints) begin
              tbl_req.we           = 1'b1;
              tbl_req.addr         = PtIdxW'(point_index_i);
              tbl_req.wdata.ptime  = point_time_i;
              tbl_req.wdata.plevel = point_level_i;
            end
            seg_d = PtIdxW'(1);
          end else if (key_pressed_i) begin
            // Held key: first look at the second-to-last breakpoint time.
            tbl_req.re   = 1'b1;
            tbl_req.addr = PtIdxW'(n_used - CountW'(2));
            ramp_d       = 1'b0;
          end else begin
            // Release ramp from the last held level.
            seg_d  = PtIdxW'(1);
            ramp_d = 1'b1;
            if (decay_zero) begin
              valid_d     = 1'b1;
              level_d     = '0;
              releasing_d = 1'b1;
            end else begin
              arith_req.start = 1'b1;
              arith_req.mag   = rel_q;
              arith_req.dt    = decay_q - elapsed_time_i;
              arith_req.span  = decay_q;
            end
          end
        end
      end
      S_SUS_CHK: begin
        tbl_req.re = 1'b1;
        if (sus_hit) begin
          seg_d        = last;
          tbl_req.addr = last;
        end else begin
          seg_d        = seg_clamp;
          tbl_req.addr = seg_clamp;
        end
      end
      S_SUS_LVL: begin
        valid_d     = 1'b1;
        level_d     = rd.plevel;
        releasing_d = 1'b0;
        rel_d       = rd.plevel;
      end
      S_SCAN: begin
        // Walk forward while time lies past the current segment end.
        tbl_req.re = 1'b1;
        if (scan_more) begin
          seg_d        = seg_q + PtIdxW'(1);
          tbl_req.addr = seg_q + PtIdxW'(1);
        end else begin
          x1_d         = rd.ptime;
          y1_d         = rd.plevel;
          tbl_req.addr = seg_q - PtIdxW'(1);
        end
      end
      S_LO: begin
        // Segment start is on the read port; an empty segment gives its start level.
        y0_d = rd.plevel;
        up_d = (y1_q >= rd.plevel);
        if (flat_seg) begin
          valid_d     = 1'b1;
          level_d     = rd.plevel;
          releasing_d = 1'b0;
          rel_d       = rd.plevel;
        end else begin
          arith_req.start = 1'b1;
          arith_req.mag   = (y1_q >= rd.plevel) ? (y1_q - rd.plevel) : (rd.plevel - y1_q);
          arith_req.dt    = t_clamp - rd.ptime;
          arith_req.span  = x1_q - rd.ptime;
        end
      end
      S_DIV: begin
        if (arith_rsp.done) begin
          valid_d     = 1'b1;
          level_d     = div_level;
          releasing_d = ramp_q;
          if (!ramp_q) rel_d = div_level;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seg_q   <= PtIdxW'(1);
      rel_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      rel_q   <= rel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    x1_q        <= x1_d;
    y1_q        <= y1_d;
    y0_q        <= y0_d;
    up_q        <= up_d;
    ramp_q      <= ramp_d;
    level_q     <= level_d;
    releasing_q <= releasing_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign level_o     = level_q;
  assign releasing_o = releasing_q;

  // The segment pointer never points at the first breakpoint's left side.
  a_seg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q != '0)
    else $error("segment pointer reached zero");

  // A held-key result is remembered as the release starting level.
  a_rel_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !releasing_o) |-> (level_o == rel_q))
    else $error("release level does not follow held output");

  // A result always closes an evaluate: the sequencer is back at rest.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (state_q == S_IDLE))
    else $error("result strobe while sequencer busy");

  // A divide finishes only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_rsp.done |-> (state_q == S_DIV))
    else $error("divide finished outside wait state");

endmodule
